// File: rtl/sact_pkg.sv
// Shared constants, payload types and write-port type of the cache tag model.
`default_nettype none

package sact_pkg;

    // Cache geometry.
    localparam int WAYS       = 4;
    localparam int LINES      = 256;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 48;

    localparam int NUM_SETS  = LINES / WAYS;
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int SET_IDX_W = $clog2(NUM_SETS);
    localparam int TAG_W     = ADDR_BITS - OFF_BITS - SET_IDX_W;

    // The replacement victim is taken from the address starting at this bit.
    localparam int VICTIM_LSB = 3;

    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_LAT = 1'b1;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [ADDR_BITS-1:0] address;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way;
        logic              evicted;
        logic [TIME_W-1:0] access_time_ps;
    } rsp_t;

    // Write port of the tag array.
    typedef struct packed {
        logic                 en;
        logic [SET_IDX_W-1:0] set;
        logic [WAY_BITS-1:0]  way;
        logic [TAG_W-1:0]     tag;
    } tag_wr_t;

endpackage

`default_nettype wire

// File: rtl/sact_tag_ram.sv
// Tag array: one memory per way, registered set read with write-first forwarding.
`default_nettype none

module sact_tag_ram
    import sact_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rd_en,
    input  wire logic [SET_IDX_W-1:0]           rd_set,
    output logic      [WAYS-1:0][TAG_W-1:0]     rd_tags,
    input  wire tag_wr_t                        wr
);

    for (genvar w = 0; w < WAYS; w++)
    begin : g_way
        logic [TAG_W-1:0] mem [NUM_SETS];
        logic [TAG_W-1:0] rd_tag_reg;
        logic             wr_here;

        assign wr_here = wr.en && (wr.way == WAY_BITS'(w));

        always_ff @(posedge clk)
        begin
            if (wr_here)
            begin
                mem[wr.set] <= wr.tag;
            end
            // A read of the set written in the same cycle sees the new tag.
            if (rd_en)
            begin
                if (wr_here && (wr.set == rd_set))
                begin
                    rd_tag_reg <= wr.tag;
                end
                else
                begin
                    rd_tag_reg <= mem[rd_set];
                end
            end
        end

        assign rd_tags[w] = rd_tag_reg;
    end

endmodule

`default_nettype wire

// File: rtl/set_assoc_cache_tag_model_core.sv
// Top level of the tag-only set-associative cache timing model.
//
// Each request item carries an operation (read or write) and a byte address.
// The block looks the tag up in the four ways of the addressed set, allocates
// the line on a miss (first invalid way, otherwise the way named by address
// bits 4:3) and returns one response item with hit, way, evicted and the
// cache's own access time, taken from the read or write time register.
// Both channels use valid/ready. The tag memory read is registered at the
// edge that accepts a request, and the compare and update happen in the
// compare stage, whose result is registered in the output register; one item
// is accepted every cycle when the response side keeps up. When the receiver
// stalls, the response stays in its output register and the item behind it
// waits in the compare stage, so req_ready drops only once both are full.
// The configuration port writes one time register per cycle and is to be used
// only while the block is idle; the block itself does not enforce this.
// Reset clears the valid bit of every line at once (no clearing pass), so
// requests may be sent right after reset; the time registers reset to zero.
`default_nettype none

module set_assoc_cache_tag_model_core
    import sact_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_t                 req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [TIME_W-1:0] rd_lat_reg;
    logic [TIME_W-1:0] wr_lat_reg;

    // Compare stage: the request whose tags are being read out of the array.
    logic s1_valid_reg;
    req_t s1_req_reg;

    // Response register.
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Valid bit per line, cleared by reset.
    logic [NUM_SETS-1:0][WAYS-1:0] valid_reg;

    logic                       req_fire;
    logic                       s1_fire;
    logic [SET_IDX_W-1:0]       s1_set;
    logic [TAG_W-1:0]           s1_tag;
    logic [WAYS-1:0][TAG_W-1:0] rd_tags;
    logic [WAYS-1:0]            valid_row;
    logic [WAYS-1:0]            tag_match;
    logic                       hit_found;
    logic [WAY_BITS-1:0]        hit_way;
    logic                       free_found;
    logic [WAY_BITS-1:0]        free_way;
    logic [WAY_BITS-1:0]        fill_way;
    rsp_t                       rsp_next;
    tag_wr_t                    tag_wr;

    // The compare stage moves on whenever the response register is free or
    // being emptied, and it takes a new item in the same cycle.
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_fire;
    assign req_fire  = req_valid && req_ready;

    assign s1_set = s1_req_reg.address[OFF_BITS +: SET_IDX_W];
    assign s1_tag = s1_req_reg.address[ADDR_BITS-1 -: TAG_W];

    always_comb
    begin
        valid_row  = valid_reg[s1_set];
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            tag_match[w] = valid_row[w] && (rd_tags[w] == s1_tag);
        end
        // Scan downward so that the lowest-numbered way wins.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (tag_match[w])
            begin
                hit_found = 1'b1;
                hit_way   = WAY_BITS'(w);
            end
            if (!valid_row[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
        end
    end

    // With the set full, the victim comes straight from the address.
    assign fill_way = free_found ? free_way
                                 : s1_req_reg.address[VICTIM_LSB +: WAY_BITS];

    always_comb
    begin
        rsp_next.hit            = hit_found;
        rsp_next.way            = hit_found ? hit_way : fill_way;
        rsp_next.evicted        = !hit_found && !free_found;
        rsp_next.access_time_ps = (s1_req_reg.operation == OP_WRITE) ? wr_lat_reg
                                                                      : rd_lat_reg;
    end

    // Misses of both kinds allocate the line.
    assign tag_wr.en  = s1_fire && !hit_found;
    assign tag_wr.set = s1_set;
    assign tag_wr.way = fill_way;
    assign tag_wr.tag = s1_tag;

    sact_tag_ram u_tag_ram (
        .clk     (clk),
        .rd_en   (req_fire),
        .rd_set  (req.address[OFF_BITS +: SET_IDX_W]),
        .rd_tags (rd_tags),
        .wr      (tag_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_lat_reg <= '0;
            wr_lat_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RD_LAT: rd_lat_reg <= cfg_data;
                CFG_WR_LAT: wr_lat_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (tag_wr.en)
            begin
                valid_reg[s1_set][fill_way] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg <= req;
        end
        if (s1_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // A line is never both hit and replaced.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.evicted))
        else $error("response reports both hit and eviction");

    // An eviction only happens when every way of the set is valid.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && rsp_next.evicted) |-> (&valid_row))
        else $error("eviction while the set still had a free way");

    // After a miss the filled line is valid.
    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tag_wr.en |=> valid_reg[$past(s1_set)][$past(fill_way)])
        else $error("filled line not marked valid");
`endif

endmodule

`default_nettype wire

// File: sim/set_assoc_cache_tag_model_core_test.sv
// Self-checking testbench of the tag-only set-associative cache timing model.
`timescale 1ns / 100ps

import sact_pkg::*;

// Keeps a private copy of the tag array and the two time registers. It works
// out the response for every accepted access and checks the response items
// in order against those predictions.
class cache_tag_predictor;

    logic [TAG_W-1:0]  line_tag [LINES];
    bit                line_valid [LINES];
    logic [TIME_W-1:0] rd_lat;
    logic [TIME_W-1:0] wr_lat;
    rsp_t              expected_lookups [$];
    int                mismatches;

    function new();
        for (int i = 0; i < LINES; i++)
        begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
        end
        rd_lat     = '0;
        wr_lat     = '0;
        mismatches = 0;
    endfunction

    function void set_times(logic [TIME_W-1:0] rd, logic [TIME_W-1:0] wr);
        rd_lat = rd;
        wr_lat = wr;
    endfunction

    // Looks the access up, allocates the line on a miss and queues the result.
    function void note_access(req_t acc);
        logic [SET_IDX_W-1:0] set_idx;
        logic [TAG_W-1:0]     tag_val;
        int                   base;
        bit                   placed;
        rsp_t                 res;

        set_idx = acc.address[OFF_BITS +: SET_IDX_W];
        tag_val = acc.address[ADDR_BITS-1 -: TAG_W];
        base    = int'(set_idx) * WAYS;
        placed  = 1'b0;
        res     = '0;

        for (int w = 0; w < WAYS; w++)
        begin
            if (!res.hit && line_valid[base + w] && line_tag[base + w] == tag_val)
            begin
                res.hit = 1'b1;
                res.way = 2'(w);
            end
        end
        if (!res.hit)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (!placed && !line_valid[base + w])
                begin
                    res.way = 2'(w);
                    placed  = 1'b1;
                end
            end
            if (!placed)
            begin
                res.way     = 2'(acc.address[VICTIM_LSB +: WAY_BITS]);
                res.evicted = 1'b1;
            end
            line_tag[base + int'(res.way)]   = tag_val;
            line_valid[base + int'(res.way)] = 1'b1;
        end
        res.access_time_ps = (acc.operation == OP_WRITE) ? wr_lat : rd_lat;
        expected_lookups.push_back(res);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_lookup(rsp_t got);
        rsp_t want;

        if (expected_lookups.size() == 0)
        begin
            report_mismatch($sformatf("response item with no access waiting: %p", got));
            return;
        end
        want = expected_lookups.pop_front();
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
        if (got.way !== want.way)
            report_mismatch($sformatf("way %0d, expected %0d", got.way, want.way));
        if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
        if (got.access_time_ps !== want.access_time_ps)
            report_mismatch($sformatf("access_time_ps %h, expected %h",
                                      got.access_time_ps, want.access_time_ps));
    endtask

endclass

module set_assoc_cache_tag_model_core_test;

    // Cycles with no item moving on either channel before the run is
    // declared hung. The longest legal quiet stretch is a sender gap plus a
    // receiver stall plus the pause around a register write, so this leaves a
    // wide margin.
    localparam int IDLE_LIMIT = 2000;

    // Cycles allowed after the last response before the final verdict, so a
    // stray extra response would still be caught.
    localparam int DRAIN_CYCLES = 8;

    localparam int PHASE_ITEMS = 90;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    cache_tag_predictor lookups = new();

    // When set, both the sender and the receiver run without gaps, so the
    // pipeline also sees long stretches at the full rate of one item a cycle.
    bit no_gaps;

    set_assoc_cache_tag_model_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Writes both time registers on consecutive cycles. The write enable
    // stays high across the two writes and is lowered once afterwards, so it
    // never gets two assignments in the same time step. Called at a falling
    // edge while the block holds no access.
    task load_latencies(logic [TIME_W-1:0] rd, logic [TIME_W-1:0] wr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RD_LAT;
        cfg_data  <= rd;
        @(negedge clk);
        cfg_index <= CFG_WR_LAT;
        cfg_data  <= wr;
        @(negedge clk);
        cfg_we <= 1'b0;
        lookups.set_times(rd, wr);
    endtask

    // Offers one access item, with a random gap in front of it unless the
    // gap-free mode is on. It is entered and left at a falling edge. The
    // valid line is only lowered when a gap follows, so a back-to-back item
    // keeps valid high without a second assignment in that step.
    task send_access(logic op, logic [ADDR_BITS-1:0] addr);
        int   gap;
        req_t item;

        gap            = no_gaps ? 0 : $urandom_range(0, 8);
        item.operation = op;
        item.address   = addr;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        lookups.note_access(item);
        @(negedge clk);
    endtask

    // Drops valid and holds the sender back until every queued response has
    // come back, then lets the two-stage pipeline settle. Apart from the first
    // load after reset, registers are rewritten only after this.
    task drain_pipeline;
        req_valid <= 1'b0;
        while (lookups.expected_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Hand-picked accesses. With 64-byte lines and 64 sets the tag starts at
    // address bit 12, so 0x1000, 0x2000, ... are distinct tags in set 0, and
    // bits 4:3 pick the victim once the set is full.
    task run_directed;
        // A miss into an empty set, then a write hit and a read hit on it.
        // The write hit must report the write time, not the read time.
        send_access(OP_READ,  48'h0000_0000_0000);
        send_access(OP_WRITE, 48'h0000_0000_0000);
        send_access(OP_READ,  48'h0000_0000_0000);
        // All-ones address: the last set and the largest tag.
        send_access(OP_READ,  48'hFFFF_FFFF_FFFF);
        send_access(OP_WRITE, 48'hFFFF_FFFF_FFFF);
        // Fill the remaining ways of set 0 in order.
        send_access(OP_WRITE, 48'h0000_0000_1000);
        send_access(OP_READ,  48'h0000_0000_2000);
        send_access(OP_READ,  48'h0000_0000_3000);
        // Set 0 is full: each new tag evicts the way named by bits 4:3.
        send_access(OP_READ,  48'h0000_0000_4000);
        send_access(OP_READ,  48'h0000_0000_5008);
        send_access(OP_WRITE, 48'h0000_0000_6010);
        send_access(OP_WRITE, 48'h0000_0000_7018);
        // Hits on the new lines, regardless of the offset bits.
        send_access(OP_READ,  48'h0000_0000_4038);
        send_access(OP_WRITE, 48'h0000_0000_7000);
        // A tag that was evicted misses again.
        send_access(OP_READ,  48'h0000_0000_1000);
        // Only the top address bit set, and the offset bits all ones.
        send_access(OP_WRITE, 48'h8000_0000_0000);
        send_access(OP_READ,  48'h0000_0000_003F);
        send_access(OP_READ,  48'h8000_0000_0000);
        send_access(OP_WRITE, 48'h0000_0000_003F);
    endtask

    // Mostly a few tags in a few sets, so hits, fills and evictions all come
    // up often; one access in five uses a fully random address so every bit
    // of the field toggles.
    task run_random(int count);
        logic [ADDR_BITS-1:0] addr;
        logic                 op;

        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 24) == 0)
                no_gaps = !no_gaps;
            op   = 1'($urandom_range(0, 1));
            addr = ADDR_BITS'({$urandom, $urandom});
            if ($urandom_range(0, 4) != 0)
            begin
                addr[ADDR_BITS-1 -: TAG_W]   = TAG_W'($urandom_range(0, 5));
                addr[OFF_BITS +: SET_IDX_W] = SET_IDX_W'($urandom_range(0, 3));
            end
            send_access(op, addr);
        end
    endtask

    // The receiver draws a stall before every response item and then holds
    // ready high until one is taken. Each taken item is checked right away.
    initial
    begin
        int stall;

        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            lookups.check_lookup(rsp);
            @(negedge clk);
        end
    end

    // Hang detection: counts consecutive cycles in which neither channel
    // moves an item.
    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed accesses, then random phases, each
    // under its own pair of time registers. The extremes of both registers
    // come first, then random values. Each phase boundary is a full drain.
    initial
    begin
        logic [TIME_W-1:0] rd_times [6];
        logic [TIME_W-1:0] wr_times [6];

        rd_times = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                     $urandom, $urandom};
        wr_times = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     $urandom, $urandom};

        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_RD_LAT;
        cfg_data  <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_latencies(32'd1500, 32'hFFFF_FFFF);
        run_directed();
        drain_pipeline();

        for (int p = 0; p < 6; p++)
        begin
            load_latencies(rd_times[p], wr_times[p]);
            run_random(PHASE_ITEMS);
            drain_pipeline();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookups.expected_lookups.size() != 0)
            lookups.report_mismatch($sformatf("%0d responses never arrived",
                                              lookups.expected_lookups.size()));
        if (lookups.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/sact_pkg.sv
rtl/sact_tag_ram.sv
rtl/set_assoc_cache_tag_model_core.sv
sim/set_assoc_cache_tag_model_core_test.sv
